/* rtl/bph_pkg.sv */
package bph_pkg;

    // Fixed field widths
    localparam int PIXEL_W    = 8;
    localparam int BIN_W      = 9;
    localparam int RESULT_W   = 32;
    localparam int PATCH_W    = 2;
    localparam int IMG_W      = 11;
    localparam int SIDE_W     = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    // Pixel codes
    localparam logic [PIXEL_W-1:0] PIXEL_FG = 8'd255;
    localparam logic [PIXEL_W-1:0] PIXEL_BG = 8'd0;

    // Item modes
    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_READ  = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PATCH_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATCH_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd2;

    // Reset values of the configuration registers
    localparam logic [PATCH_W-1:0] PATCH_RESET = 2'd3;
    localparam logic [IMG_W-1:0]   IMAGE_RESET = 11'd1024;

    typedef struct packed {
        logic               mode;
        logic [PIXEL_W-1:0] pixel;
        logic               first_of_image;
        logic [BIN_W-1:0]   bin_index;
    } t_pix_item;

    typedef struct packed {
        logic                window_done;
        logic [BIN_W-1:0]    pattern;
        logic [RESULT_W-1:0] bin_count;
        logic                bad_pixel;
    } t_res_item;

    // Request from the window stage to the histogram stage
    typedef struct packed {
        logic             valid;
        logic             rd;
        logic             inc;
        logic             bad;
        logic [BIN_W-1:0] addr;
    } t_hist_req;

    typedef struct packed {
        logic clearing;
    } t_hist_status;

endpackage

/* rtl/bph_pix_if.sv */
interface bph_pix_if;
    import bph_pkg::*;

    logic               valid;
    logic               ready;
    logic               mode;
    logic [PIXEL_W-1:0] pixel;
    logic               first_of_image;
    logic [BIN_W-1:0]   bin_index;

    modport source (output valid, mode, pixel, first_of_image, bin_index, input ready);
    modport sink   (input valid, mode, pixel, first_of_image, bin_index, output ready);
endinterface

/* rtl/bph_res_if.sv */
interface bph_res_if;
    import bph_pkg::*;

    logic                valid;
    logic                ready;
    logic                window_done;
    logic [BIN_W-1:0]    pattern;
    logic [RESULT_W-1:0] bin_count;
    logic                bad_pixel;

    modport source (output valid, window_done, pattern, bin_count, bad_pixel, input ready);
    modport sink   (input valid, window_done, pattern, bin_count, bad_pixel, output ready);
endinterface

/* rtl/bph_line.sv */
module bph_line #(
    parameter int MAX_PATCH_SIDE = 3,
    parameter int MAX_COLUMNS    = 1024,
    parameter int XW             = 11
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_take,
    input  bph_pkg::t_pix_item        i_item,
    input  logic [bph_pkg::SIDE_W-1:0] i_pw,
    input  logic [bph_pkg::SIDE_W-1:0] i_ph,
    input  logic [XW-1:0]             i_wid,
    output bph_pkg::t_hist_req        o_req
);
    import bph_pkg::*;

    localparam int S   = MAX_PATCH_SIDE;
    localparam int CW  = $clog2(MAX_COLUMNS);
    localparam int LW  = (S > 1) ? S - 1 : 1;
    localparam int RW  = (S > 1) ? $clog2(S) : 1;
    localparam int NW  = S * S;
    localparam int NWB = (NW > 1) ? $clog2(NW) : 1;
    localparam logic [LW-1:0] LINE_MASK = LW'((1 << (S - 1)) - 1);
    localparam logic [RW-1:0] ROWS_MAX  = RW'(S - 1);

    // Position and window state
    logic [CW-1:0] r_pos, n_pos;
    logic [RW-1:0] r_rows, n_rows;
    logic [NW-1:0] r_win, n_win;

    // First stage: item plus line store read
    logic          r1_valid;
    logic          r1_mode;
    logic          r1_bit;
    logic          r1_bad;
    logic          r1_done;
    logic [CW-1:0] r1_col;
    logic [BIN_W-1:0] r1_bin;
    logic [LW-1:0] r_line_rd;

    // Last line store write, for forwarding
    logic          r_lw_valid;
    logic [CW-1:0] r_lw_col;
    logic [LW-1:0] r_lw_data;

    logic [LW-1:0] line_mem [MAX_COLUMNS];

    t_hist_req     r_req;

    logic          pix_item;
    logic [CW-1:0] col;
    logic [RW-1:0] rows;
    logic [XW-1:0] col_x;
    logic          done;
    logic          row_end;
    logic          pix_bit;
    logic          bad;

    logic [LW-1:0] old_line;
    logic [LW-1:0] new_line;
    logic [S-1:0]  column;
    logic [BIN_W-1:0] n_code;

    // Position of the incoming pixel
    always_comb begin
        pix_item = (i_item.mode == MODE_PIXEL);
        col      = i_item.first_of_image ? '0 : r_pos;
        rows     = i_item.first_of_image ? '0 : r_rows;
        col_x    = XW'(col) + XW'(1);
        done     = (col_x >= XW'(i_pw)) && ((4'(rows) + 4'd1) >= 4'(i_ph));
        row_end  = (col_x >= i_wid);
        pix_bit  = (i_item.pixel == PIXEL_FG);
        bad      = (i_item.pixel != PIXEL_FG) && (i_item.pixel != PIXEL_BG);
        n_pos    = row_end ? '0 : CW'(col_x);
        n_rows   = (row_end && (rows < ROWS_MAX)) ? rows + RW'(1) : rows;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_rows   <= '0;
            r1_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_take;
            if (i_take && pix_item) begin
                r_pos  <= n_pos;
                r_rows <= n_rows;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_mode <= i_item.mode;
            r1_bit  <= pix_bit;
            r1_bad  <= pix_item && bad;
            r1_done <= done;
            r1_col  <= col;
            r1_bin  <= i_item.bin_index;
        end
    end

    // Second stage: column vector, window shift and pattern code
    always_comb begin
        old_line = (r_lw_valid && (r_lw_col == r1_col)) ? r_lw_data : r_line_rd;
        new_line = LW'({old_line, r1_bit}) & LINE_MASK;
        column   = '0;
        column[S-1] = r1_bit;
        for (int k = 1; k < S; k++) begin
            column[S-1-k] = old_line[k-1];
        end
        for (int r = 0; r < S; r++) begin
            for (int c = 0; c < S - 1; c++) begin
                n_win[r*S+c] = r_win[r*S+c+1];
            end
            n_win[r*S+S-1] = column[r];
        end
    end

    // Select the active window corner, row-major with top-left at bit 0
    always_comb begin
        int idx;
        int wi;
        n_code = '0;
        for (int r = 0; r < S; r++) begin
            for (int c = 0; c < S; c++) begin
                idx = r * int'(i_pw) + c;
                wi  = (S - int'(i_ph) + r) * S + (S - int'(i_pw) + c);
                if ((r < int'(i_ph)) && (c < int'(i_pw))) begin
                    n_code[idx[3:0]] = n_win[wi[NWB-1:0]];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win      <= '0;
            r_lw_valid <= 1'b0;
            r_req      <= '0;
        end else if (i_en) begin
            r_lw_valid   <= r1_valid && (r1_mode == MODE_PIXEL);
            r_req.valid  <= r1_valid;
            r_req.rd     <= (r1_mode == MODE_READ);
            r_req.inc    <= (r1_mode == MODE_PIXEL) && r1_done;
            r_req.bad    <= r1_bad;
            if (r1_mode == MODE_READ) begin
                r_req.addr <= r1_bin;
            end else begin
                r_req.addr <= r1_done ? n_code : '0;
            end
            if (r1_valid && (r1_mode == MODE_PIXEL)) begin
                r_win <= n_win;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lw_col  <= r1_col;
            r_lw_data <= new_line;
        end
    end

    // Line store: bit k-1 of an entry is the pixel k rows above
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_line_rd <= line_mem[col];
            if (r1_valid && (r1_mode == MODE_PIXEL)) begin
                line_mem[r1_col] <= new_line;
            end
        end
    end

    assign o_req = r_req;

endmodule

/* rtl/bph_hist.sv */
module bph_hist #(
    parameter int HIST_AW    = 9,
    parameter int COUNT_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  bph_pkg::t_hist_req    i_req,
    output bph_pkg::t_hist_status o_status,
    output logic                  o_valid,
    output bph_pkg::t_res_item    o_item
);
    import bph_pkg::*;

    localparam int HD = 1 << HIST_AW;
    localparam logic [HIST_AW-1:0] LAST_ADDR = HIST_AW'(HD - 1);

    logic [COUNT_BITS-1:0] hist_mem [HD];

    t_hist_req             r2;
    logic [COUNT_BITS-1:0] r_rd;

    logic                  r_hw_valid;
    logic [HIST_AW-1:0]    r_hw_addr;
    logic [COUNT_BITS-1:0] r_hw_data;

    logic                  r_clearing;
    logic [HIST_AW-1:0]    r_clr_addr;

    logic                  r_out_valid;
    t_res_item             r_out, n_out;

    logic [HIST_AW-1:0]    rd_addr;
    logic [HIST_AW-1:0]    wr_addr;
    logic [COUNT_BITS-1:0] old_cnt;
    logic [COUNT_BITS-1:0] new_cnt;
    logic                  in_range;

    assign rd_addr = i_req.addr[HIST_AW-1:0];
    assign wr_addr = r2.addr[HIST_AW-1:0];

    // Read-modify-write with forwarding of the previous update
    always_comb begin
        old_cnt  = (r_hw_valid && (r_hw_addr == wr_addr)) ? r_hw_data : r_rd;
        new_cnt  = (&old_cnt) ? old_cnt : old_cnt + COUNT_BITS'(1);
        in_range = ({1'b0, r2.addr} < 10'(HD));
        n_out    = '0;
        if (r2.rd) begin
            n_out.pattern   = r2.addr;
            n_out.bin_count = in_range ? RESULT_W'(old_cnt) : '0;
        end else if (r2.inc) begin
            n_out.window_done = 1'b1;
            n_out.pattern     = r2.addr;
            n_out.bin_count   = RESULT_W'(new_cnt);
            n_out.bad_pixel   = r2.bad;
        end else begin
            n_out.bad_pixel   = r2.bad;
        end
    end

    // Control: request stage, forwarding, clearing pass, output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2          <= '0;
            r_hw_valid  <= 1'b0;
            r_clearing  <= 1'b1;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + HIST_AW'(1);
                if (r_clr_addr == LAST_ADDR) begin
                    r_clearing <= 1'b0;
                end
            end
            if (i_en) begin
                r2          <= i_req;
                r_hw_valid  <= r2.valid && r2.inc;
                r_out_valid <= r2.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hw_addr <= wr_addr;
            r_hw_data <= new_cnt;
            r_out     <= n_out;
        end
    end

    // Histogram memory
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rd <= hist_mem[rd_addr];
        end
        if (r_clearing) begin
            hist_mem[r_clr_addr] <= '0;
        end else if (i_en && r2.valid && r2.inc) begin
            hist_mem[wr_addr] <= new_cnt;
        end
    end

    assign o_status.clearing = r_clearing;
    assign o_valid           = r_out_valid;
    assign o_item            = r_out;

endmodule

/* rtl/binary_patch_histogram_unit.sv */
// Binary patch histogram: takes one pixel or bin-read item per clock and returns one result
// per item, registered in turn by the line store read, the pattern request, the histogram
// read and the output register. Throughput is one item per cycle, set by the read-modify-write
// of the histogram memory with forwarding of the previous update; the block stalls only while
// the result register is full and not taken. After reset the histogram is zeroed by a
// clearing pass that writes each of the 2^min(MAX_PATCH_SIDE^2, 9) bins (512 at the default),
// during which no item is taken; configuration writes are taken at any time.
module binary_patch_histogram_unit #(
    parameter int MAX_PATCH_SIDE = 3,
    parameter int MAX_COLUMNS    = 1024,
    parameter int COUNT_BITS     = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bph_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bph_pkg::CFG_DATA_W-1:0] i_cfg_data,
    bph_pix_if.sink                        i_pix,
    bph_res_if.source                      o_res
);
    import bph_pkg::*;

    localparam int S       = MAX_PATCH_SIDE;
    localparam int HIST_AW = (S * S < BIN_W) ? S * S : BIN_W;
    localparam int XW      = ($clog2(MAX_COLUMNS + 1) > IMG_W) ? $clog2(MAX_COLUMNS + 1) : IMG_W;

    logic [PATCH_W-1:0] r_patch_width;
    logic [PATCH_W-1:0] r_patch_height;
    logic [IMG_W-1:0]   r_image_width;

    logic [SIDE_W-1:0]  pw_raw, ph_raw, pw, ph;
    logic [XW-1:0]      iw, wid;

    logic               en;
    logic               take;
    t_pix_item          item;
    t_hist_req          req;
    t_hist_status       status;
    logic               out_valid;
    t_res_item          out_item;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_patch_width  <= PATCH_RESET;
            r_patch_height <= PATCH_RESET;
            r_image_width  <= IMAGE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PATCH_WIDTH:  r_patch_width  <= i_cfg_data[PATCH_W-1:0];
                CFG_PATCH_HEIGHT: r_patch_height <= i_cfg_data[PATCH_W-1:0];
                CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data[IMG_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp sizes to their legal ranges
    always_comb begin
        pw_raw = SIDE_W'(r_patch_width);
        ph_raw = SIDE_W'(r_patch_height);
        pw     = (pw_raw == '0) ? SIDE_W'(1) : ((pw_raw > SIDE_W'(S)) ? SIDE_W'(S) : pw_raw);
        ph     = (ph_raw == '0) ? SIDE_W'(1) : ((ph_raw > SIDE_W'(S)) ? SIDE_W'(S) : ph_raw);
        iw     = XW'(r_image_width);
        wid    = (iw == '0) ? XW'(1) : ((iw > XW'(MAX_COLUMNS)) ? XW'(MAX_COLUMNS) : iw);
    end

    // Whole pipeline advances while the result register can take a new item
    assign en          = !out_valid || o_res.ready;
    assign i_pix.ready = en && !status.clearing;
    assign take        = i_pix.valid && i_pix.ready;

    assign item.mode           = i_pix.mode;
    assign item.pixel          = i_pix.pixel;
    assign item.first_of_image = i_pix.first_of_image;
    assign item.bin_index      = i_pix.bin_index;

    bph_line #(
        .MAX_PATCH_SIDE (MAX_PATCH_SIDE),
        .MAX_COLUMNS    (MAX_COLUMNS),
        .XW             (XW)
    ) u_line (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_take  (take),
        .i_item  (item),
        .i_pw    (pw),
        .i_ph    (ph),
        .i_wid   (wid),
        .o_req   (req)
    );

    bph_hist #(
        .HIST_AW    (HIST_AW),
        .COUNT_BITS (COUNT_BITS)
    ) u_hist (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_req    (req),
        .o_status (status),
        .o_valid  (out_valid),
        .o_item   (out_item)
    );

    assign o_res.valid       = out_valid;
    assign o_res.window_done = out_item.window_done;
    assign o_res.pattern     = out_item.pattern;
    assign o_res.bin_count   = out_item.bin_count;
    assign o_res.bad_pixel   = out_item.bad_pixel;

    // No item may enter while the histogram is being cleared
    a_no_take_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.clearing |-> !i_pix.ready)
        else $error("item taken during histogram clearing");

    // An updated bin is never zero after its increment
    a_updated_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.window_done) |-> (o_res.bin_count != '0))
        else $error("updated bin reports zero count");

    // No result of any kind comes out during the clearing pass
    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.clearing |-> !o_res.valid)
        else $error("result present during histogram clearing");

endmodule
